// ----- hdl/fagr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fagr_pkg;

  // operand and result widths
  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned PROD_W        = 2 * OPERAND_WIDTH;
  localparam int unsigned NUM_W         = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned DEN_W         = 2 * OPERAND_WIDTH;
  localparam int unsigned K_W           = $clog2(NUM_W + 1);
  localparam int unsigned CNT_W         = $clog2(NUM_W);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    OP_ADD     = 3'd0,
    OP_MUL     = 3'd1,
    OP_ADD_RED = 3'd2,
    OP_CMP     = 3'd3,
    OP_BUILD   = 3'd4
  } op_e;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [OPERAND_WIDTH-1:0] left_num;
    logic [OPERAND_WIDTH-1:0] left_den;
    logic [OPERAND_WIDTH-1:0] right_num;
    logic [OPERAND_WIDTH-1:0] right_den;
  } arg_t;

  // result word
  typedef struct packed {
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic             is_equal;
    logic             not_equal;
  } res_t;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MS_LN_RD,
    MS_LD_RN,
    MS_LN_RN,
    MS_LD_RD
  } mul_sel_e;

  // numerator register sources
  typedef enum logic [2:0] {
    N_HOLD,
    N_PROD,
    N_ADD,
    N_LEFT,
    N_ZERO,
    N_QUO
  } n_sel_e;

  // denominator register sources
  typedef enum logic [2:0] {
    D_HOLD,
    D_PROD,
    D_LEFT,
    D_ONE,
    D_QUO
  } d_sel_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_CHECK,
    S_GCD,
    S_DIV_N,
    S_WB_N,
    S_DIV_D,
    S_WB_D,
    S_FINISH
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     blank_set;
    logic     mul_en;
    mul_sel_e mul_sel;
    n_sel_e   n_sel;
    d_sel_e   d_sel;
    logic     gcd_init;
    logic     gcd_step;
    logic     g_form;
    logic     div_init;
    logic     div_src_den;
    logic     div_step;
    logic     res_en;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             left_zero;
    logic             nd_zero;
    logic             gcd_eq;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/fagr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fagr_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fagr_pkg::arg_t arg_i,
  input  wire fagr_pkg::ctl_t ctl_i,
  output fagr_pkg::sts_t      sts_o,
  output fagr_pkg::res_t      res_o
);
  import fagr_pkg::*;

  arg_t               arg_q;
  logic               blank_q;
  logic [OPERAND_WIDTH-1:0] mul_a;
  logic [OPERAND_WIDTH-1:0] mul_b;
  logic [PROD_W-1:0]  prod_q;
  logic [NUM_W-1:0]   n_q, n_d;
  logic [DEN_W-1:0]   d_q, d_d;
  logic [NUM_W-1:0]   a_q, a_d;
  logic [NUM_W-1:0]   b_q, b_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [NUM_W-1:0]   g_q;
  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [NUM_W:0]     trial;
  logic               fits;
  logic               match;
  logic               is_cmp;
  res_t               res_q;

  // input word capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      arg_q <= arg_i;
    end
  end

  // blank result marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= 1'b0;
    end else if (ctl_i.load) begin
      blank_q <= 1'b0;
    end else if (ctl_i.blank_set) begin
      blank_q <= 1'b1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (ctl_i.mul_sel)
      MS_LN_RD: begin
        mul_a = arg_q.left_num;
        mul_b = arg_q.right_den;
      end
      MS_LD_RN: begin
        mul_a = arg_q.left_den;
        mul_b = arg_q.right_num;
      end
      MS_LN_RN: begin
        mul_a = arg_q.left_num;
        mul_b = arg_q.right_num;
      end
      default: begin
        mul_a = arg_q.left_den;
        mul_b = arg_q.right_den;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // numerator and denominator working registers
  always_comb begin
    case (ctl_i.n_sel)
      N_PROD:  n_d = NUM_W'(prod_q);
      N_ADD:   n_d = n_q + NUM_W'(prod_q);
      N_LEFT:  n_d = NUM_W'(arg_q.left_num);
      N_ZERO:  n_d = '0;
      N_QUO:   n_d = quo_q;
      default: n_d = n_q;
    endcase
    case (ctl_i.d_sel)
      D_PROD:  d_d = prod_q;
      D_LEFT:  d_d = DEN_W'(arg_q.left_den);
      D_ONE:   d_d = DEN_W'(1);
      D_QUO:   d_d = quo_q[DEN_W-1:0];
      default: d_d = d_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
  end

  // binary gcd, one halving or subtraction per cycle
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (ctl_i.gcd_init) begin
      a_d = n_q;
      b_d = NUM_W'(d_q);
      k_d = '0;
    end else if (ctl_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + K_W'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    if (ctl_i.g_form) begin
      g_q <= a_q << k_q;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, g_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctl_i.div_init) begin
      rem_d = '0;
      quo_d = ctl_i.div_src_den ? NUM_W'(d_q) : n_q;
    end else if (ctl_i.div_step) begin
      rem_d = fits ? NUM_W'(trial - {1'b0, g_q}) : trial[NUM_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // result word and comparison flags
  assign is_cmp = (arg_q.cmd == OP_CMP) && !blank_q;
  assign match  = (n_q == NUM_W'(arg_q.right_num)) && (d_q == DEN_W'(arg_q.right_den));

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_en) begin
      res_q.res_num   <= n_q;
      res_q.res_den   <= d_q;
      res_q.is_equal  <= is_cmp && match;
      res_q.not_equal <= is_cmp && !match;
    end
  end

  assign res_o = res_q;

  // status to controller
  assign sts_o.cmd       = arg_q.cmd;
  assign sts_o.empty     = (arg_q.left_num == '0) && (arg_q.left_den == OPERAND_WIDTH'(1));
  assign sts_o.left_zero = (arg_q.left_num == '0) || (arg_q.left_den == '0);
  assign sts_o.nd_zero   = (n_q == '0) || (d_q == '0);
  assign sts_o.gcd_eq    = (a_q == b_q);

`ifndef SYNTH
  // the gcd must divide the value exactly
  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.n_sel == N_QUO || ctl_i.d_sel == D_QUO) |-> rem_q == '0)
    else $error("division by gcd left a remainder");

  // the gcd loop never runs on a zero value
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.gcd_step |-> (a_q != '0) && (b_q != '0))
    else $error("gcd step on a zero operand");
`endif

endmodule

`default_nettype wire

// ----- hdl/fagr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fagr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output logic                done_o,
  input  wire fagr_pkg::sts_t sts_i,
  output fagr_pkg::ctl_t      ctl_o
);
  import fagr_pkg::*;

  localparam logic [CNT_W-1:0] CntLast = CNT_W'(NUM_W - 1);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  op_e                op;

  assign op = op_e'(sts_i.cmd);

  // state, step counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op) inside
          OP_ADD, OP_MUL, OP_ADD_RED: begin
            if (sts_i.empty) begin
              ctl_o.n_sel     = N_ZERO;
              ctl_o.d_sel     = D_ONE;
              ctl_o.blank_set = 1'b1;
              state_d         = S_FINISH;
            end else begin
              state_d = S_MUL0;
            end
          end
          OP_CMP: begin
            ctl_o.n_sel = sts_i.empty ? N_ZERO : N_LEFT;
            ctl_o.d_sel = sts_i.empty ? D_ONE : D_LEFT;
            ctl_o.blank_set = sts_i.empty;
            state_d     = sts_i.empty ? S_FINISH : S_CHECK;
          end
          OP_BUILD: begin
            ctl_o.n_sel = sts_i.left_zero ? N_ZERO : N_LEFT;
            ctl_o.d_sel = sts_i.left_zero ? D_ONE : D_LEFT;
            ctl_o.blank_set = sts_i.left_zero;
            state_d     = sts_i.left_zero ? S_FINISH : S_CHECK;
          end
          default: begin
            // undefined command gives 0/1
            ctl_o.n_sel     = N_ZERO;
            ctl_o.d_sel     = D_ONE;
            ctl_o.blank_set = 1'b1;
            state_d         = S_FINISH;
          end
        endcase
      end
      // products: first numerator term, second term, denominator
      S_MUL0: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = (op == OP_MUL) ? MS_LN_RN : MS_LN_RD;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        ctl_o.n_sel   = N_PROD;
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MS_LD_RN;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        ctl_o.n_sel   = (op == OP_MUL) ? N_HOLD : N_ADD;
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MS_LD_RD;
        state_d       = S_MUL3;
      end
      S_MUL3: begin
        ctl_o.d_sel = D_PROD;
        state_d     = (op == OP_ADD_RED) ? S_CHECK : S_FINISH;
      end
      // a zero on either side leaves the fraction as it is
      S_CHECK: begin
        if (sts_i.nd_zero) begin
          state_d = S_FINISH;
        end else begin
          ctl_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_eq) begin
          ctl_o.g_form   = 1'b1;
          ctl_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV_N;
        end else begin
          ctl_o.gcd_step = 1'b1;
        end
      end
      S_DIV_N: begin
        ctl_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CntLast) begin
          state_d = S_WB_N;
        end
      end
      S_WB_N: begin
        ctl_o.n_sel       = N_QUO;
        ctl_o.div_init    = 1'b1;
        ctl_o.div_src_den = 1'b1;
        cnt_d             = '0;
        state_d           = S_DIV_D;
      end
      S_DIV_D: begin
        ctl_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CntLast) begin
          state_d = S_WB_D;
        end
      end
      S_WB_D: begin
        ctl_o.d_sel = D_QUO;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        ctl_o.res_en = 1'b1;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef SYNTH
  // one strobe per word
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // the strobe comes with the unit back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  // an accepted word makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !done_o)
    else $error("accepted word did not start the unit");

  // divider counter only runs inside the division states
  a_cnt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.div_step |-> (state_q == S_DIV_N || state_q == S_DIV_D))
    else $error("divider step outside division");
`endif

endmodule

`default_nettype wire

// ----- hdl/fraction_arith_gcd_reduce_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rational arithmetic unit: add, multiply, add and reduce, compare against a
// reduced left fraction, and build a reduced fraction, on 16-bit operands.
// A word is taken when start is high and busy is low; busy then stays high
// until the result word appears for one cycle with done_o, and the receiver
// must take it then, as it cannot stall the unit. One word is in flight at a
// time. An empty left fraction, an undefined command and build with a zero
// operand go from dispatch straight to the result; compare with a zero
// numerator or denominator adds only the zero check; add and multiply pass
// through the multiplier states; add and reduce whose sum or denominator is
// zero adds the zero check. Reduction adds the binary gcd loop, one halving or
// subtraction per cycle, and two restoring divisions, numerator then
// denominator, on one shared divider, each followed by a write-back.
// The gcd loop and the bit-serial divider set the run time of a reduction.

module fraction_arith_gcd_reduce_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fagr_pkg::arg_t arg_i,
  output logic                done_o,
  output fagr_pkg::res_t      res_o
);
  import fagr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  fagr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // multiplier, gcd and divider datapath
  fagr_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .arg_i  (arg_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ----- tb/fraction_arith_gcd_reduce_top_test.sv -----
`timescale 1ns / 1ps

module fraction_arith_gcd_reduce_top_test;

  import fagr_pkg::*;

  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned CALM_TAIL    = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TIME  = 250;

  // one queued word and whether the sender drains the unit before it
  typedef struct packed {
    arg_t word;
    logic drain;
  } queued_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  arg_t arg_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  queued_word_t words_to_send[$];
  res_t         fractions_due[$];
  int unsigned  gap_left    = 0;
  int unsigned  quiet_count = 0;
  int unsigned  errors      = 0;

  fraction_arith_gcd_reduce_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .arg_i  (arg_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  // greatest common divisor, one when either side is zero
  function automatic logic [63:0] common_divisor(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    if (a == 0 || b == 0) return 64'd1;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // expected result word for one accepted argument word
  function automatic res_t predict_fraction(arg_t a);
    logic [63:0] ln, ld, rn, rd, n, d, g;
    logic        empty;
    res_t        r;
    ln    = 64'(a.left_num);
    ld    = 64'(a.left_den);
    rn    = 64'(a.right_num);
    rd    = 64'(a.right_den);
    empty = (ln == 0 && ld == 1);
    n     = 64'd0;
    d     = 64'd1;
    r     = '0;
    case (a.cmd)
      OP_ADD, OP_ADD_RED: begin
        if (!empty) begin
          n = ln * rd + ld * rn;
          d = ld * rd;
          if (a.cmd == OP_ADD_RED) begin
            g = common_divisor(n, d);
            n = n / g;
            d = d / g;
          end
        end
      end
      OP_MUL: begin
        if (!empty) begin
          n = ln * rn;
          d = ld * rd;
        end
      end
      OP_CMP: begin
        if (!empty) begin
          g = common_divisor(ln, ld);
          n = ln / g;
          d = ld / g;
          r.is_equal  = (n == rn && d == rd);
          r.not_equal = !(n == rn && d == rd);
        end
      end
      OP_BUILD: begin
        if (ln != 0 && ld != 0) begin
          g = common_divisor(ln, ld);
          n = ln / g;
          d = ld / g;
        end
      end
      default: ;
    endcase
    r.res_num = n[NUM_W-1:0];
    r.res_den = d[DEN_W-1:0];
    return r;
  endfunction

  function automatic void queue_word(logic [CMD_W-1:0] cmd, int ln, int ld, int rn, int rd,
                                     logic drain = 1'b0);
    queued_word_t q;
    q.word.cmd       = cmd;
    q.word.left_num  = OPERAND_WIDTH'(ln);
    q.word.left_den  = OPERAND_WIDTH'(ld);
    q.word.right_num = OPERAND_WIDTH'(rn);
    q.word.right_den = OPERAND_WIDTH'(rd);
    q.drain          = drain;
    words_to_send.push_back(q);
  endfunction

  // operand drawn from small, full-range, near-max, power-of-two and composite values
  function automatic int random_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 12);
      1:       return $urandom_range(0, 65535);
      2:       return 65535 - $urandom_range(0, 3);
      3:       return 1 << $urandom_range(0, 15);
      default: return $urandom_range(1, 255) * $urandom_range(1, 255);
    endcase
  endfunction

  // mostly valid commands, with shared factors, empty lefts and matching compares
  function automatic void queue_random_word(logic drain);
    logic [CMD_W-1:0] cmd;
    int               ln, ld, rn, rd, k;
    arg_t             probe;
    res_t             reduced;
    if ($urandom_range(0, 99) < 4) cmd = CMD_W'($urandom_range(5, 7));
    else                           cmd = CMD_W'($urandom_range(0, 4));
    ln = random_operand();
    ld = random_operand();
    rn = random_operand();
    rd = random_operand();
    if ($urandom_range(0, 2) == 0) begin
      k  = $urandom_range(2, 60);
      ln = k * $urandom_range(0, 65535 / k);
      ld = k * $urandom_range(1, 65535 / k);
    end
    if ($urandom_range(0, 15) == 0) begin
      ln = 0;
      ld = 1;
    end
    if (cmd == OP_CMP && ln != 0 && ld != 0 && $urandom_range(0, 2) == 0) begin
      probe           = '0;
      probe.cmd       = OP_BUILD;
      probe.left_num  = OPERAND_WIDTH'(ln);
      probe.left_den  = OPERAND_WIDTH'(ld);
      reduced         = predict_fraction(probe);
      rn              = int'(reduced.res_num[OPERAND_WIDTH-1:0]);
      rd              = int'(reduced.res_den[OPERAND_WIDTH-1:0]);
    end
    queue_word(cmd, ln, ld, rn, rd, drain);
  endfunction

  function automatic void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endfunction

  // sender: next word from the queue, with random bursts of idling
  always @(posedge clk_i) begin : sender
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        fractions_due.push_back(predict_fraction(arg_i));
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (words_to_send.size() == 0) begin
          start <= 1'b0;
        end else if (words_to_send[0].drain && fractions_due.size() != 0) begin
          start <= 1'b0;
        end else if (words_to_send.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
          start <= 1'b0;
        end else begin
          arg_i <= words_to_send[0].word;
          start <= 1'b1;
          void'(words_to_send.pop_front());
        end
      end
    end
  end

  // receiver: check each result word against the oldest prediction, plus stall watchdog
  always @(posedge clk_i) begin : receiver
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (fractions_due.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, res_o);
          errors++;
        end else begin
          want = fractions_due.pop_front();
          if (res_o.res_num !== want.res_num)
            report_mismatch("res_num", 64'(want.res_num), 64'(res_o.res_num));
          if (res_o.res_den !== want.res_den)
            report_mismatch("res_den", 64'(want.res_den), 64'(res_o.res_den));
          if (res_o.is_equal !== want.is_equal)
            report_mismatch("is_equal", 64'(want.is_equal), 64'(res_o.is_equal));
          if (res_o.not_equal !== want.not_equal)
            report_mismatch("not_equal", 64'(want.not_equal), 64'(res_o.not_equal));
        end
      end
      if (done_o || (start && !busy)) quiet_count = 0;
      else                            quiet_count++;
      if (quiet_count >= STALL_LIMIT) begin
        $display("fraction_arith_gcd_reduce_top_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    // extremes of every operation
    queue_word(OP_ADD,     0,     0,     0,     0);
    queue_word(OP_ADD,     65535, 65535, 65535, 65535);
    queue_word(OP_MUL,     65535, 65535, 65535, 65535);
    queue_word(OP_ADD_RED, 65535, 65535, 65535, 65535);
    queue_word(OP_CMP,     65535, 1,     65535, 1);
    queue_word(OP_BUILD,   65535, 65535, 0,     0);
    // empty left fraction, and an empty right one
    queue_word(OP_ADD,     0,     1,     3,     4);
    queue_word(OP_MUL,     0,     1,     3,     4);
    queue_word(OP_ADD_RED, 0,     1,     3,     4);
    queue_word(OP_CMP,     0,     1,     0,     1);
    queue_word(OP_MUL,     3,     4,     0,     1);
    // compare hit and miss
    queue_word(OP_CMP,     6,     4,     3,     2);
    queue_word(OP_CMP,     6,     4,     6,     4);
    // build with a zero operand, and a real reduction
    queue_word(OP_BUILD,   0,     5,     1,     1);
    queue_word(OP_BUILD,   7,     0,     1,     1);
    queue_word(OP_BUILD,   12,    18,    0,     0);
    queue_word(OP_BUILD,   46368, 28657, 0,     0);
    // zero on one side of the gcd leaves the fraction as it is
    queue_word(OP_ADD_RED, 0,     5,     0,     7);
    queue_word(OP_ADD_RED, 7,     0,     0,     1);
    queue_word(OP_CMP,     0,     5,     0,     5);
    queue_word(OP_CMP,     7,     0,     7,     0);
    // undefined commands
    queue_word(CMD_W'(5),  9,     3,     4,     2);
    queue_word(CMD_W'(6),  65535, 65535, 65535, 65535);
    queue_word(CMD_W'(7),  1,     1,     1,     1);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      queue_random_word(i % 110 == 0);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (words_to_send.size() != 0 || start || fractions_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_TIME) @(posedge clk_i);

    if (errors == 0) begin
      $display("fraction_arith_gcd_reduce_top_test: done, clean");
    end else begin
      $display("fraction_arith_gcd_reduce_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fagr_pkg.sv
hdl/fagr_dp.sv
hdl/fagr_ctrl.sv
hdl/fraction_arith_gcd_reduce_top.sv
tb/fraction_arith_gcd_reduce_top_test.sv
